// ===== hw/rtl/zcd_pkg.sv =====
// Shared types, constants and CRC helpers for the ZipCrypto stream decryptor.
package zcd_pkg;

    localparam logic [31:0] CRC_POLY      = 32'hedb88320;
    localparam logic [31:0] LCG_MULT      = 32'd134775813;
    localparam logic [31:0] INIT_KEY_ZERO = 32'd305419896;
    localparam logic [31:0] INIT_KEY_ONE  = 32'd591751049;
    localparam logic [31:0] INIT_KEY_TWO  = 32'd878082192;
    localparam logic [3:0]  COUNT_MAX     = 4'd15;
    localparam logic [3:0]  CMF_POS       = 4'd12;
    localparam logic [3:0]  FLG_POS       = 4'd13;
    localparam logic [3:0]  ZLIB_METHOD   = 4'd8;
    localparam logic        OP_PASSWORD   = 1'b0;
    localparam logic        OP_CIPHER     = 1'b1;

    typedef struct packed {
        logic       op;
        logic [7:0] data;
        logic       first;
    } t_in_item;

    typedef struct packed {
        logic [7:0] plain;
        logic [3:0] position;
        logic       zlib_header_ok;
    } t_out_item;

    function automatic logic [31:0] crc_reduce8(input logic [7:0] idx);
        logic [31:0] v;
        v = {24'd0, idx};
        for (int i = 0; i < 8; i++) begin
            v = v[0] ? (CRC_POLY ^ (v >> 1)) : (v >> 1);
        end
        return v;
    endfunction

    function automatic logic [31:0] crc_step(input logic [31:0] x, input logic [7:0] c);
        return crc_reduce8(x[7:0] ^ c) ^ (x >> 8);
    endfunction

    // Since 32 is one more than 31, folding 5-bit digits keeps the residue.
    function automatic logic mod31_zero(input logic [15:0] w);
        logic [6:0] s;
        logic [5:0] f;
        s = 7'(w[4:0]) + 7'(w[9:5]) + 7'(w[14:10]) + 7'(w[15]);
        f = 6'(s[4:0]) + 6'(s[6:5]);
        return (f == 6'd0) || (f == 6'd31);
    endfunction

endpackage

// ===== hw/rtl/zcd_mul_unit.sv =====
// Shared multiplier with a registered low-word product for the decryptor.
module zcd_mul_unit (
    input  logic        i_clk,
    input  logic        i_en,
    input  logic [31:0] i_a,
    input  logic [31:0] i_b,
    output logic [31:0] o_p
);

    logic [31:0] r_p;
    logic [31:0] n_p;

    assign n_p = i_a * i_b;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_p <= n_p;
        end
    end

    assign o_p = r_p;

endmodule

// ===== hw/rtl/zipcrypto_stream_decryptor.sv =====
// Top level of the ZipCrypto stream decryptor: key sequencer and item channels.
//
// Input items carry op, data and first. A password item (op 0) only updates
// the three keys and produces no result. A ciphertext item (op 1) produces one
// result item with the plaintext byte, its stream position (saturating at 15)
// and a flag that is set at position 13 when bytes 12 and 13 form a valid zlib
// header. Setting first reloads the initial keys and clears the position before
// the item is handled.
// One shared multiplier is used twice per ciphertext item, once for the
// keystream product and once for the key one update, so the sequencer walks
// through S_KS, S_K0, S_MUL and S_K2 for a ciphertext item and S_K0, S_MUL and
// S_K2 for a password item; o_in_ready is high only while the sequencer is
// idle. The result item enters the output register in S_K2 and waits there
// until taken; the next input item may be accepted meanwhile, but the sequencer
// holds in its last step if the output register is still full when the next
// result is ready. Reset returns the keys to their initial values, clears the
// position and the saved header byte, and empties the output register.
module zipcrypto_stream_decryptor (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_ready,
    input  zcd_pkg::t_in_item   i_in_item,
    output logic                o_out_valid,
    input  logic                i_out_ready,
    output zcd_pkg::t_out_item  o_out_item
);

    import zcd_pkg::*;

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_KS   = 3'd1;
    localparam logic [2:0] S_K0   = 3'd2;
    localparam logic [2:0] S_MUL  = 3'd3;
    localparam logic [2:0] S_K2   = 3'd4;

    logic [2:0]  r_state;
    logic [31:0] r_key0;
    logic [31:0] r_key1;
    logic [31:0] r_key2;
    logic [3:0]  r_count;
    logic [7:0]  r_cmf;
    logic        r_op;
    logic [7:0]  r_byte;
    logic [31:0] r_sum;
    logic        r_out_valid;
    t_out_item   r_out;

    logic        in_acc;
    logic        out_free;
    logic        mul_en;
    logic [31:0] mul_a;
    logic [31:0] mul_b;
    logic [31:0] mul_p;
    logic [15:0] ks_t;
    logic [7:0]  n_byte;
    logic [31:0] n_key0;
    logic [31:0] n_key1;
    logic [31:0] n_key2;
    logic        n_ok;

    assign o_in_ready  = (r_state == S_IDLE);
    assign in_acc      = i_in_valid && o_in_ready;
    assign out_free    = !r_out_valid || i_out_ready;
    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out;

    assign ks_t = r_key2[15:0] | 16'd2;

    always_comb begin
        mul_en = 1'b0;
        mul_a  = {16'd0, ks_t};
        mul_b  = {16'd0, ks_t ^ 16'd1};
        unique case (r_state)
            S_KS: begin
                mul_en = 1'b1;
            end
            S_MUL: begin
                mul_en = 1'b1;
                mul_a  = r_sum;
                mul_b  = LCG_MULT;
            end
            default: begin
                mul_en = 1'b0;
            end
        endcase
    end

    zcd_mul_unit u_mul (
        .i_clk (i_clk),
        .i_en  (mul_en),
        .i_a   (mul_a),
        .i_b   (mul_b),
        .o_p   (mul_p)
    );

    assign n_byte = (r_op == OP_CIPHER) ? (r_byte ^ mul_p[15:8]) : r_byte;
    assign n_key0 = crc_step(r_key0, n_byte);
    assign n_key1 = mul_p + 32'd1;
    assign n_key2 = crc_step(r_key2, n_key1[31:24]);
    assign n_ok   = (r_count == FLG_POS) && (r_cmf[3:0] == ZLIB_METHOD)
                    && mod31_zero({r_cmf, r_byte});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_key0      <= INIT_KEY_ZERO;
            r_key1      <= INIT_KEY_ONE;
            r_key2      <= INIT_KEY_TWO;
            r_count     <= 4'd0;
            r_cmf       <= 8'd0;
            r_out_valid <= 1'b0;
        end else begin
            if (r_out_valid && i_out_ready) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (in_acc) begin
                        r_op   <= i_in_item.op;
                        r_byte <= i_in_item.data;
                        if (i_in_item.first) begin
                            r_key0  <= INIT_KEY_ZERO;
                            r_key1  <= INIT_KEY_ONE;
                            r_key2  <= INIT_KEY_TWO;
                            r_count <= 4'd0;
                            r_cmf   <= 8'd0;
                        end
                        r_state <= (i_in_item.op == OP_CIPHER) ? S_KS : S_K0;
                    end
                end
                S_KS: begin
                    r_state <= S_K0;
                end
                S_K0: begin
                    r_byte  <= n_byte;
                    r_key0  <= n_key0;
                    r_sum   <= r_key1 + {24'd0, n_key0[7:0]};
                    r_state <= S_MUL;
                end
                S_MUL: begin
                    r_state <= S_K2;
                end
                S_K2: begin
                    if (r_op == OP_PASSWORD) begin
                        r_key1  <= n_key1;
                        r_key2  <= n_key2;
                        r_state <= S_IDLE;
                    end else if (out_free) begin
                        r_key1               <= n_key1;
                        r_key2               <= n_key2;
                        r_out.plain          <= r_byte;
                        r_out.position       <= r_count;
                        r_out.zlib_header_ok <= n_ok;
                        r_out_valid          <= 1'b1;
                        if (r_count == CMF_POS) begin
                            r_cmf <= r_byte;
                        end
                        if (r_count != COUNT_MAX) begin
                            r_count <= r_count + 4'd1;
                        end
                        r_state <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

`ifndef NO_ASSERTIONS
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_acc |=> !o_in_ready)
        else $error("input accepted again while the sequencer was busy");

    a_password_no_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_acc && (i_in_item.op == OP_PASSWORD) && !r_out_valid) |=> !o_out_valid)
        else $error("password item produced a result");

    a_hold_when_blocked: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((r_state == S_K2) && (r_op == OP_CIPHER) && r_out_valid && !i_out_ready)
        |=> ((r_state == S_K2) && $stable(r_key1) && $stable(r_count)))
        else $error("sequencer advanced while the output register was full");

    a_count_monotonic: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_rst_n && !(in_acc && i_in_item.first)) |=> (r_count >= $past(r_count)))
        else $error("position went backwards without a first item");

    a_ok_only_at_flg: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out.zlib_header_ok) |-> (r_out.position == FLG_POS))
        else $error("header flag set away from position thirteen");
`endif

endmodule

// ===== sim/zipcrypto_stream_decryptor_tb.sv =====
// Self-checking testbench for the ZipCrypto stream decryptor with a bit-exact key predictor.
module zipcrypto_stream_decryptor_tb;
    import zcd_pkg::*;

    localparam int CYCLE_LIMIT    = 400000;
    localparam int HOLD_CYCLES    = 300;
    localparam int TARGET_ITEMS   = 1150;
    localparam int HDR_VALID      = 0;
    localparam int HDR_BAD_METHOD = 1;
    localparam int HDR_BAD_CHECK  = 2;
    localparam int HDR_RANDOM     = 3;

    class zcd_plain_scoreboard;
        logic [31:0] key_a;
        logic [31:0] key_b;
        logic [31:0] key_c;
        logic [3:0]  byte_pos;
        logic [7:0]  cmf_byte;
        t_out_item   pending_plain[$];
        int          mismatches;

        function new();
            reload();
            mismatches = 0;
        endfunction

        function void reload();
            key_a = INIT_KEY_ZERO;
            key_b = INIT_KEY_ONE;
            key_c = INIT_KEY_TWO;
            byte_pos = 4'd0;
            cmf_byte = 8'd0;
        endfunction

        function logic [31:0] crc_byte(logic [31:0] x, logic [7:0] c);
            logic [31:0] v;
            v = {24'd0, x[7:0] ^ c};
            for (int i = 0; i < 8; i++) begin
                v = (v >> 1) ^ (v[0] ? CRC_POLY : 32'd0);
            end
            return v ^ (x >> 8);
        endfunction

        function void mix_keys(logic [7:0] c);
            key_a = crc_byte(key_a, c);
            key_b = (key_b + {24'd0, key_a[7:0]}) * LCG_MULT + 32'd1;
            key_c = crc_byte(key_c, key_b[31:24]);
        endfunction

        function logic [7:0] keystream_for(logic restart);
            logic [31:0] t;
            logic [31:0] prod;
            t = {16'd0, (restart ? INIT_KEY_TWO[15:0] : key_c[15:0]) | 16'd2};
            prod = t * (t ^ 32'd1);
            return prod[15:8];
        endfunction

        function void note_input(t_in_item it);
            t_out_item want;
            if (it.first) reload();
            if (it.op == OP_PASSWORD) begin
                mix_keys(it.data);
                return;
            end
            want.plain = it.data ^ keystream_for(1'b0);
            mix_keys(want.plain);
            want.position = byte_pos;
            want.zlib_header_ok = 1'b0;
            if (byte_pos == CMF_POS) cmf_byte = want.plain;
            if (byte_pos == FLG_POS && cmf_byte[3:0] == ZLIB_METHOD
                    && ({cmf_byte, want.plain} % 31) == 0) begin
                want.zlib_header_ok = 1'b1;
            end
            if (byte_pos != COUNT_MAX) byte_pos++;
            pending_plain.push_back(want);
        endfunction

        function void check_plain(t_out_item got);
            t_out_item want;
            if (pending_plain.size() == 0) begin
                $error("unexpected result item: plain %0h position %0d zlib_header_ok %0b",
                       got.plain, got.position, got.zlib_header_ok);
                mismatches++;
                return;
            end
            want = pending_plain.pop_front();
            if (got.plain !== want.plain) begin
                $error("plain: expected %0h, actual %0h", want.plain, got.plain);
                mismatches++;
            end
            if (got.position !== want.position) begin
                $error("position: expected %0d, actual %0d", want.position, got.position);
                mismatches++;
            end
            if (got.zlib_header_ok !== want.zlib_header_ok) begin
                $error("zlib_header_ok: expected %0b, actual %0b",
                       want.zlib_header_ok, got.zlib_header_ok);
                mismatches++;
            end
        endfunction
    endclass

    logic      i_clk = 1'b0;
    logic      i_rst_n = 1'b0;
    logic      in_valid = 1'b0;
    logic      in_ready;
    t_in_item  in_item = '0;
    logic      out_valid;
    logic      out_ready = 1'b0;
    t_out_item out_item;
    bit        no_gaps = 1'b0;
    bit        hold_request = 1'b0;
    int        cycles = 0;
    int        item_count = 0;
    zcd_plain_scoreboard sb = new();

    zipcrypto_stream_decryptor DUT (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (in_valid),
        .o_in_ready  (in_ready),
        .i_in_item   (in_item),
        .o_out_valid (out_valid),
        .i_out_ready (out_ready),
        .o_out_item  (out_item)
    );

    always #5 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT) begin
            $display("tb: failure");
            $finish;
        end
    end

    task automatic send_item(input t_in_item it);
        int gap;
        gap = no_gaps ? 0 : $urandom_range(0, 14);
        if (gap > 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        in_valid <= 1'b1;
        in_item <= it;
        do begin
            @(posedge i_clk);
        end while (in_ready !== 1'b1);
        sb.note_input(it);
        item_count++;
    endtask

    task automatic send_op(input logic op, input logic [7:0] data, input logic first);
        t_in_item it;
        it.op = op;
        it.data = data;
        it.first = first;
        send_item(it);
    endtask

    task automatic send_plain(input logic [7:0] plain, input logic first);
        send_op(OP_CIPHER, plain ^ sb.keystream_for(first), first);
    endtask

    task automatic drain();
        in_valid <= 1'b0;
        while (sb.pending_plain.size() != 0) @(posedge i_clk);
    endtask

    task automatic send_stream(input int pw_len, input int tail_len, input int header_kind);
        logic [7:0]  cmf;
        logic [7:0]  flg;
        logic [15:0] base;
        logic        lead;
        lead = 1'b1;
        for (int i = 0; i < pw_len; i++) begin
            send_op(OP_PASSWORD, 8'($urandom), lead);
            lead = 1'b0;
        end
        for (int i = 0; i < 12; i++) begin
            send_op(OP_CIPHER, 8'($urandom), lead);
            lead = 1'b0;
            if ($urandom_range(0, 19) == 0) send_op(OP_PASSWORD, 8'($urandom), 1'b0);
        end
        cmf = {4'($urandom), ZLIB_METHOD};
        if (header_kind == HDR_BAD_METHOD) cmf[3:0] = ZLIB_METHOD ^ 4'($urandom_range(1, 15));
        base = {cmf, 3'($urandom), 5'd0};
        flg = {base[7:5], 5'((31 - base % 31) % 31)};
        if (header_kind == HDR_BAD_CHECK) flg[4:0] = flg[4:0] + 5'd1;
        if (header_kind == HDR_RANDOM) begin
            cmf = 8'($urandom);
            flg = 8'($urandom);
        end
        send_plain(cmf, 1'b0);
        send_plain(flg, 1'b0);
        for (int i = 0; i < tail_len; i++) begin
            if ($urandom_range(0, 9) == 0) send_op(OP_PASSWORD, 8'($urandom), 1'b0);
            else send_op(OP_CIPHER, 8'($urandom), 1'b0);
        end
    endtask

    initial begin : result_sink
        int stall;
        wait (i_rst_n === 1'b1);
        forever begin
            if (hold_request) begin
                stall = HOLD_CYCLES;
                hold_request = 1'b0;
            end else begin
                stall = no_gaps ? 0 : $urandom_range(0, 14);
            end
            if (stall > 0) begin
                out_ready <= 1'b0;
                repeat (stall) @(posedge i_clk);
            end
            out_ready <= 1'b1;
            do begin
                @(posedge i_clk);
            end while (out_valid !== 1'b1);
            sb.check_plain(out_item);
        end
    end

    initial begin : stimulus
        int kind;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;

        send_op(OP_PASSWORD, 8'h00, 1'b1);
        send_op(OP_PASSWORD, 8'hff, 1'b0);
        send_op(OP_CIPHER, 8'h00, 1'b0);
        send_op(OP_CIPHER, 8'hff, 1'b0);
        send_op(OP_PASSWORD, 8'h5a, 1'b0);
        send_op(OP_CIPHER, 8'ha5, 1'b1);
        send_op(OP_CIPHER, 8'h3c, 1'b0);
        send_op(OP_PASSWORD, 8'h81, 1'b1);
        send_plain(8'h00, 1'b0);
        send_plain(8'hff, 1'b0);
        send_stream(0, 4, HDR_VALID);

        drain();
        hold_request = 1'b1;
        no_gaps = 1'b1;
        for (int i = 0; i < 10; i++) send_op(OP_CIPHER, 8'($urandom), 1'b0);
        no_gaps = 1'b0;
        drain();

        while (item_count < TARGET_ITEMS) begin
            if ($urandom_range(0, 5) == 0) no_gaps = !no_gaps;
            case ($urandom_range(0, 11))
                0, 1: begin
                    for (int i = $urandom_range(1, 8); i > 0; i--) begin
                        send_op(1'($urandom), 8'($urandom), $urandom_range(0, 3) == 0);
                    end
                end
                2: drain();
                default: begin
                    kind = $urandom_range(0, 1) ? HDR_VALID
                                                : $urandom_range(HDR_BAD_METHOD, HDR_RANDOM);
                    send_stream($urandom_range(0, 6),
                                $urandom_range(0, 4) == 0 ? $urandom_range(0, 30)
                                                          : $urandom_range(0, 6),
                                kind);
                end
            endcase
        end

        drain();
        repeat (20) @(posedge i_clk);
        if (sb.mismatches == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule
